### hw/rtl/stsc_pkg.sv
// Package for the serial time-set clock: character codes, parser phase codes,
// line and day constants, reply job type and small constant-divisor helpers.
// Self-contained; used by serial_time_set_clock_top.
package stsc_pkg;

  // Line buffer capacity (characters kept is LineCap-1)
  localparam int unsigned LineCap = 32;
  localparam int unsigned CountW  = $clog2(LineCap);

  // Parsed magnitude and its saturation value
  localparam int unsigned ValW = 63;
  localparam logic [ValW-1:0] SatMax = {ValW{1'b1}};

  // Day clock limits
  localparam int unsigned DaySec  = 86400;
  localparam int unsigned MsPerSec = 1000;
  localparam logic [9:0]  MsLast  = 10'(MsPerSec - 1);
  localparam logic [5:0]  SecLast = 6'd59;
  localparam logic [5:0]  MinLast = 6'd59;
  localparam logic [4:0]  HourLast = 5'd23;

  // Clock value that a saturated parse sets, split into h:m:s
  localparam longint unsigned SatSod = 64'h7FFF_FFFF_FFFF_FFFF % 64'd86400;
  localparam logic [4:0] SatHour = 5'(SatSod / 3600);
  localparam logic [5:0] SatMin  = 6'((SatSod % 3600) / 60);
  localparam logic [5:0] SatSec  = 6'(SatSod % 60);

  // Input kinds carried in tuser
  localparam logic ModeByte = 1'b0;
  localparam logic ModeTick = 1'b1;

  // Parser phases
  localparam logic [1:0] PhBlank = 2'd0;
  localparam logic [1:0] PhSign  = 2'd1;
  localparam logic [1:0] PhDigit = 2'd2;
  localparam logic [1:0] PhStop  = 2'd3;

  // Character codes
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChE     = 8'h45;
  localparam logic [7:0] ChK     = 8'h4B;
  localparam logic [7:0] ChO     = 8'h4F;
  localparam logic [7:0] ChR     = 8'h52;
  localparam logic [7:0] ChT     = 8'h54;

  // Reply positions of the newline
  localparam logic [3:0] OkLastIdx  = 4'd8;
  localparam logic [3:0] ErrLastIdx = 4'd3;

  // One pending reply: clock snapshot at line end
  typedef struct packed {
    logic       ok;
    logic [4:0] hour;
    logic [5:0] minute;
  } job_t;

  // floor(x/60) for x < 600, by parallel threshold compares
  function automatic logic [3:0] quo60(input logic [9:0] x);
    logic [3:0] q;
    q = '0;
    for (int j = 1; j < 10; j++) begin
      if (x >= 10'(60 * j)) q = 4'(j);
    end
    return q;
  endfunction

  // floor(x/24) for x < 240
  function automatic logic [3:0] quo24(input logic [7:0] x);
    logic [3:0] q;
    q = '0;
    for (int j = 1; j < 10; j++) begin
      if (x >= 8'(24 * j)) q = 4'(j);
    end
    return q;
  endfunction

  // floor(x/10) for x < 60
  function automatic logic [3:0] quo10(input logic [5:0] x);
    logic [3:0] q;
    q = '0;
    for (int j = 1; j < 6; j++) begin
      if (x >= 6'(10 * j)) q = 4'(j);
    end
    return q;
  endfunction

endpackage

### hw/rtl/serial_time_set_clock_top.sv
// Serial time-set clock (line parser, day clock, reply serializer); uses stsc_pkg.
// A line end is processed while its beat sits in the input register; the job it pushes
// passes through the reply queue, the serializer and the output register to m_axis.
// Throughput: one input beat per cycle; a reply leaves at one byte per cycle while m_axis
// is ready, through a one-job queue; a line end waits while queue and serializer are full.
// Reset (rst_ni low, asynchronous) clears the line and all stages; clock unset, 00:00.
module serial_time_set_clock_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] rx_byte
  input  logic       s_axis_tuser_i,   // [0] mode (0 byte, 1 ms tick)
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] reply_byte
  output logic       m_axis_tlast_o    // last reply byte (newline)
);

  // Input register
  logic       in_v_q;
  logic       in_mode_q;
  logic [7:0] in_byte_q;

  // Line and parser state
  logic [stsc_pkg::CountW-1:0] cnt_q, cnt_d;
  logic                        t_q, t_d;
  logic [1:0]                  ph_q, ph_d;
  logic                        neg_q, neg_d;
  logic                        seen_q, seen_d;
  logic [stsc_pkg::ValW-1:0]   pv_q, pv_d;
  logic                        sat_q, sat_d;
  logic [4:0]                  rh_q, rh_d;
  logic [5:0]                  rm_q, rm_d;
  logic [5:0]                  rs_q, rs_d;

  // Day clock
  logic       cv_q, cv_d;
  logic [4:0] hr_q, hr_d;
  logic [5:0] mn_q, mn_d;
  logic [5:0] sc_q, sc_d;
  logic [9:0] ms_q, ms_d;

  // Reply queue and serializer
  logic            job_v_q;
  stsc_pkg::job_t  job_q, job_d;
  logic            em_busy_q;
  logic            em_ok_q;
  logic [3:0]      em_idx_q;
  logic [3:0]      em_h1_q, em_h0_q, em_m1_q, em_m0_q;
  logic            out_v_q;
  logic [7:0]      out_byte_q;
  logic            out_last_q;

  logic is_byte, is_eol, line_end, do_proc, job_take, push, em_step;
  logic in_take;

  // Digit step wires
  logic       is_dig, take_dig;
  logic [3:0] dig;
  logic [9:0] s_x, m_x;
  logic [7:0] h_x;
  logic [3:0] cs, cm, ch;
  logic [stsc_pkg::ValW+3:0] v10;
  logic       ovf;
  logic       set_clk;

  // Serializer wires
  logic [7:0] em_char;
  logic       em_last;
  logic [3:0] h1, m1;

  assign is_byte  = (in_mode_q == stsc_pkg::ModeByte);
  assign is_eol   = (in_byte_q == stsc_pkg::ChLf) || (in_byte_q == stsc_pkg::ChCr);
  assign line_end = is_byte && is_eol && (cnt_q != '0);
  assign job_take = job_v_q && !em_busy_q;
  assign do_proc  = in_v_q && !(line_end && job_v_q && !job_take);
  assign push     = do_proc && line_end;
  assign s_axis_tready_o = !in_v_q || do_proc;
  assign in_take  = s_axis_tvalid_i && s_axis_tready_o;

  // Residue of the parsed value mod one day, kept as h:m:s, times ten plus digit
  assign is_dig = (in_byte_q >= stsc_pkg::ChZero) && (in_byte_q <= stsc_pkg::ChNine);
  assign dig    = in_byte_q[3:0];
  assign s_x    = 10'(rs_q) * 10'd10 + 10'(dig);
  assign cs     = stsc_pkg::quo60(s_x);
  assign m_x    = 10'(rm_q) * 10'd10 + 10'(cs);
  assign cm     = stsc_pkg::quo60(m_x);
  assign h_x    = 8'(rh_q) * 8'd10 + 8'(cm);
  assign ch     = stsc_pkg::quo24(h_x);

  // Full magnitude times ten plus digit, for saturation
  assign v10 = ({4'b0, pv_q} << 3) + ({4'b0, pv_q} << 1) + (stsc_pkg::ValW+4)'(dig);
  assign ovf = |v10[stsc_pkg::ValW+3:stsc_pkg::ValW];

  assign set_clk = t_q && seen_q && !neg_q && (pv_q != '0);

  // Line parser
  always_comb begin
    cnt_d  = cnt_q;
    t_d    = t_q;
    ph_d   = ph_q;
    neg_d  = neg_q;
    seen_d = seen_q;
    pv_d   = pv_q;
    sat_d  = sat_q;
    rh_d   = rh_q;
    rm_d   = rm_q;
    rs_d   = rs_q;
    take_dig = 1'b0;
    if (do_proc && is_byte) begin
      if (is_eol || (cnt_q >= stsc_pkg::CountW'(stsc_pkg::LineCap - 1))) begin
        cnt_d  = '0;
        t_d    = 1'b0;
        ph_d   = stsc_pkg::PhBlank;
        neg_d  = 1'b0;
        seen_d = 1'b0;
        pv_d   = '0;
        sat_d  = 1'b0;
        rh_d   = '0;
        rm_d   = '0;
        rs_d   = '0;
      end else begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == '0) begin
          t_d = (in_byte_q == stsc_pkg::ChT);
        end else begin
          unique case (ph_q)
            stsc_pkg::PhBlank: begin
              if ((in_byte_q == stsc_pkg::ChSpace) || (in_byte_q == stsc_pkg::ChTab) ||
                  (in_byte_q == stsc_pkg::ChVt) || (in_byte_q == stsc_pkg::ChFf)) begin
                ph_d = stsc_pkg::PhBlank;
              end else if ((in_byte_q == stsc_pkg::ChPlus) ||
                           (in_byte_q == stsc_pkg::ChMinus)) begin
                neg_d = (in_byte_q == stsc_pkg::ChMinus);
                ph_d  = stsc_pkg::PhSign;
              end else if (is_dig) begin
                ph_d = stsc_pkg::PhDigit;
                take_dig = 1'b1;
              end else begin
                ph_d = stsc_pkg::PhStop;
              end
            end
            stsc_pkg::PhSign, stsc_pkg::PhDigit: begin
              if (is_dig) begin
                ph_d = stsc_pkg::PhDigit;
                take_dig = 1'b1;
              end else begin
                ph_d = stsc_pkg::PhStop;
              end
            end
            default: ph_d = stsc_pkg::PhStop;
          endcase
        end
        if (take_dig) begin
          seen_d = 1'b1;
          pv_d   = ovf ? stsc_pkg::SatMax : v10[stsc_pkg::ValW-1:0];
          sat_d  = sat_q || ovf;
          rs_d   = 6'(s_x - 10'(cs) * 10'd60);
          rm_d   = 6'(m_x - 10'(cm) * 10'd60);
          rh_d   = 5'(h_x - 8'(ch) * 8'd24);
        end
      end
    end
  end

  // Day clock: ms ticks and set at line end
  always_comb begin
    cv_d = cv_q;
    hr_d = hr_q;
    mn_d = mn_q;
    sc_d = sc_q;
    ms_d = ms_q;
    if (do_proc && !is_byte) begin
      if (ms_q == stsc_pkg::MsLast) begin
        ms_d = '0;
        if (sc_q == stsc_pkg::SecLast) begin
          sc_d = '0;
          if (mn_q == stsc_pkg::MinLast) begin
            mn_d = '0;
            hr_d = (hr_q == stsc_pkg::HourLast) ? 5'd0 : hr_q + 5'd1;
          end else begin
            mn_d = mn_q + 6'd1;
          end
        end else begin
          sc_d = sc_q + 6'd1;
        end
      end else begin
        ms_d = ms_q + 10'd1;
      end
    end else if (push && set_clk) begin
      cv_d = 1'b1;
      ms_d = '0;
      hr_d = sat_q ? stsc_pkg::SatHour : rh_q;
      mn_d = sat_q ? stsc_pkg::SatMin  : rm_q;
      sc_d = sat_q ? stsc_pkg::SatSec  : rs_q;
    end
  end

  // Snapshot for the reply
  always_comb begin
    job_d.ok     = cv_d;
    job_d.hour   = hr_d;
    job_d.minute = mn_d;
  end

  // Reply character at the serializer position
  always_comb begin
    em_char = stsc_pkg::ChLf;
    if (em_ok_q) begin
      unique case (em_idx_q)
        4'd0:    em_char = stsc_pkg::ChO;
        4'd1:    em_char = stsc_pkg::ChK;
        4'd2:    em_char = stsc_pkg::ChSpace;
        4'd3:    em_char = stsc_pkg::ChZero + 8'(em_h1_q);
        4'd4:    em_char = stsc_pkg::ChZero + 8'(em_h0_q);
        4'd5:    em_char = stsc_pkg::ChColon;
        4'd6:    em_char = stsc_pkg::ChZero + 8'(em_m1_q);
        4'd7:    em_char = stsc_pkg::ChZero + 8'(em_m0_q);
        default: em_char = stsc_pkg::ChLf;
      endcase
    end else begin
      unique case (em_idx_q)
        4'd0:    em_char = stsc_pkg::ChE;
        4'd1:    em_char = stsc_pkg::ChR;
        4'd2:    em_char = stsc_pkg::ChR;
        default: em_char = stsc_pkg::ChLf;
      endcase
    end
  end

  assign em_last = em_ok_q ? (em_idx_q == stsc_pkg::OkLastIdx)
                           : (em_idx_q == stsc_pkg::ErrLastIdx);
  assign em_step = em_busy_q && (!out_v_q || m_axis_tready_i);
  assign h1 = stsc_pkg::quo10({1'b0, job_q.hour});
  assign m1 = stsc_pkg::quo10(job_q.minute);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q    <= 1'b0;
      in_mode_q <= stsc_pkg::ModeByte;
      in_byte_q <= '0;
    end else begin
      if (in_take) begin
        in_v_q    <= 1'b1;
        in_mode_q <= s_axis_tuser_i;
        in_byte_q <= s_axis_tdata_i;
      end else if (do_proc) begin
        in_v_q <= 1'b0;
      end
    end
  end

  // Parser and clock state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      t_q    <= 1'b0;
      ph_q   <= stsc_pkg::PhBlank;
      neg_q  <= 1'b0;
      seen_q <= 1'b0;
      pv_q   <= '0;
      sat_q  <= 1'b0;
      rh_q   <= '0;
      rm_q   <= '0;
      rs_q   <= '0;
      cv_q   <= 1'b0;
      hr_q   <= '0;
      mn_q   <= '0;
      sc_q   <= '0;
      ms_q   <= '0;
    end else begin
      cnt_q  <= cnt_d;
      t_q    <= t_d;
      ph_q   <= ph_d;
      neg_q  <= neg_d;
      seen_q <= seen_d;
      pv_q   <= pv_d;
      sat_q  <= sat_d;
      rh_q   <= rh_d;
      rm_q   <= rm_d;
      rs_q   <= rs_d;
      cv_q   <= cv_d;
      hr_q   <= hr_d;
      mn_q   <= mn_d;
      sc_q   <= sc_d;
      ms_q   <= ms_d;
    end
  end

  // One-entry reply queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_v_q <= 1'b0;
      job_q   <= '0;
    end else begin
      if (push) begin
        job_v_q <= 1'b1;
        job_q   <= job_d;
      end else if (job_take) begin
        job_v_q <= 1'b0;
      end
    end
  end

  // Serializer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_busy_q  <= 1'b0;
      em_ok_q    <= 1'b0;
      em_idx_q   <= '0;
      em_h1_q    <= '0;
      em_h0_q    <= '0;
      em_m1_q    <= '0;
      em_m0_q    <= '0;
      out_v_q    <= 1'b0;
      out_byte_q <= '0;
      out_last_q <= 1'b0;
    end else begin
      if (job_take) begin
        em_busy_q <= 1'b1;
        em_ok_q   <= job_q.ok;
        em_idx_q  <= '0;
        em_h1_q   <= h1;
        em_h0_q   <= 4'(5'(job_q.hour) - 5'(h1) * 5'd10);
        em_m1_q   <= m1;
        em_m0_q   <= 4'(job_q.minute - 6'(m1) * 6'd10);
      end else if (em_step) begin
        em_busy_q <= !em_last;
        em_idx_q  <= em_idx_q + 4'd1;
      end
      if (em_step) begin
        out_v_q    <= 1'b1;
        out_byte_q <= em_char;
        out_last_q <= em_last;
      end else if (m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

### verif/serial_time_set_clock_top_test.sv
// Stream-level test of serial_time_set_clock_top: replies to byte and tick beats are checked
// against an in-bench model of the line parser and day clock, over four idle/stall phases.
// Depends on stsc_pkg and serial_time_set_clock_top.
module serial_time_set_clock_top_test;
  import stsc_pkg::*;

  localparam int unsigned IdleLimit  = 3000;  // cycles with no beat on either side
  localparam int unsigned HoldCycles = 400;   // long receiver hold-off
  localparam int unsigned PhaseBeats = 60;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned MaxPrints  = 30;

  typedef struct packed {
    logic       mode;
    logic [7:0] ch;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } reply_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;   // [7:0] rx_byte
  logic       s_tuser = 1'b0; // [0] mode
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;        // [7:0] reply_byte
  logic       m_tlast;

  // Stimulus and expectations
  in_beat_t    beat_q[$];
  reply_t      reply_q[$];
  int unsigned fed_cnt;
  int unsigned err_cnt;
  int unsigned idle_pct;
  int unsigned stall_pct;
  logic        hold_arm;
  logic        hold_done;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  // Model state: line parser and day clock
  logic [4:0]  ln_len;
  logic        ln_t;
  logic [1:0]  ln_phase;
  logic        ln_neg;
  logic        ln_digit;
  logic [62:0] ln_num;
  logic        clk_set;
  logic [16:0] clk_sod;
  logic [9:0]  clk_ms;

  serial_time_set_clock_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MaxPrints) $display("MISMATCH: %s", msg);
  endtask

  task automatic want_char(input logic [7:0] ch, input logic last);
    reply_q.push_back('{ch: ch, last: last});
  endtask

  task automatic clear_line();
    ln_len   = '0;
    ln_t     = 1'b0;
    ln_phase = PhBlank;
    ln_neg   = 1'b0;
    ln_digit = 1'b0;
    ln_num   = '0;
  endtask

  // Advance the model by one accepted beat and queue the reply it causes
  task automatic take_beat(input logic mode, input logic [7:0] ch);
    logic        is_dig;
    logic        use_dig;
    logic [63:0] dval;
    int unsigned hh;
    int unsigned mm;
    is_dig  = (ch >= ChZero) && (ch <= ChNine);
    use_dig = 1'b0;
    if (mode == ModeTick) begin
      if (clk_ms == MsLast) begin
        clk_ms = '0;
        if (clk_sod == 17'(DaySec - 1)) clk_sod = '0;
        else clk_sod = clk_sod + 17'd1;
      end else begin
        clk_ms = clk_ms + 10'd1;
      end
    end else if (ch == ChLf || ch == ChCr) begin
      if (ln_len != 0) begin
        if (ln_t && ln_digit && !ln_neg && ln_num != 0) begin
          clk_sod = 17'({1'b0, ln_num} % 64'(DaySec));
          clk_ms  = '0;
          clk_set = 1'b1;
        end
        if (clk_set) begin
          hh = clk_sod / 3600;
          mm = (clk_sod % 3600) / 60;
          want_char(ChO, 1'b0);
          want_char(ChK, 1'b0);
          want_char(ChSpace, 1'b0);
          want_char(8'(ChZero + hh / 10), 1'b0);
          want_char(8'(ChZero + hh % 10), 1'b0);
          want_char(ChColon, 1'b0);
          want_char(8'(ChZero + mm / 10), 1'b0);
          want_char(8'(ChZero + mm % 10), 1'b0);
          want_char(ChLf, 1'b1);
        end else begin
          want_char(ChE, 1'b0);
          want_char(ChR, 1'b0);
          want_char(ChR, 1'b0);
          want_char(ChLf, 1'b1);
        end
      end
      clear_line();
    end else if (ln_len < 5'(LineCap - 1)) begin
      if (ln_len == 0) begin
        ln_t = (ch == ChT);
      end else begin
        // strtoll-like scan: blanks, one sign, digits, then stop
        case (ln_phase)
          PhBlank: begin
            if (ch == ChSpace || ch == ChTab || ch == ChVt || ch == ChFf) begin
              ln_phase = PhBlank;
            end else if (ch == ChPlus || ch == ChMinus) begin
              ln_neg   = (ch == ChMinus);
              ln_phase = PhSign;
            end else if (!is_dig) begin
              ln_phase = PhStop;
            end else begin
              ln_phase = PhDigit;
              use_dig  = 1'b1;
            end
          end
          PhSign, PhDigit: begin
            if (!is_dig) begin
              ln_phase = PhStop;
            end else begin
              ln_phase = PhDigit;
              use_dig  = 1'b1;
            end
          end
          default: ln_phase = PhStop;
        endcase
        if (use_dig) begin
          dval     = 64'(ch - ChZero);
          ln_digit = 1'b1;
          if ({1'b0, ln_num} > ({1'b0, SatMax} - dval) / 64'd10) ln_num = SatMax;
          else ln_num = 63'({1'b0, ln_num} * 64'd10 + dval);
        end
      end
      ln_len = ln_len + 5'd1;
    end else begin
      // character past the line capacity drops the whole line
      clear_line();
    end
  endtask

  // Stimulus helpers
  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == ChLf || c == ChCr);
    return c;
  endfunction

  function automatic logic [7:0] line_end();
    return $urandom_range(1) ? ChLf : ChCr;
  endfunction

  task automatic push_beat(input logic mode, input logic [7:0] ch);
    beat_q.push_back('{mode: mode, ch: ch});
    fed_cnt++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_beat(ModeByte, s[i]);
  endtask

  task automatic push_ticks(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_beat(ModeTick, 8'($urandom_range(255)));
  endtask

  // One random line or fragment; about half are T set commands, most of them well-formed
  task automatic add_sequence();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(99);
    if (kind < 50) begin
      push_beat(ModeByte, ChT);
      if ($urandom_range(7) == 0) push_ticks(1);
      n = $urandom_range(2);
      for (int unsigned i = 0; i < n; i++) begin
        case ($urandom_range(3))
          0: push_beat(ModeByte, ChSpace);
          1: push_beat(ModeByte, ChTab);
          2: push_beat(ModeByte, ChVt);
          default: push_beat(ModeByte, ChFf);
        endcase
      end
      case ($urandom_range(3))
        0: push_beat(ModeByte, ChPlus);
        1: push_beat(ModeByte, ChMinus);
        default: ;
      endcase
      if ($urandom_range(9) == 0) push_beat(ModeByte, text_byte());
      // mostly short numbers, now and then long enough to saturate
      n = ($urandom_range(9) == 0) ? $urandom_range(19, 24) : $urandom_range(1, 6);
      for (int unsigned i = 0; i < n; i++) push_beat(ModeByte, 8'(ChZero + $urandom_range(9)));
      if ($urandom_range(3) == 0) begin
        n = $urandom_range(1, 3);
        for (int unsigned i = 0; i < n; i++) push_beat(ModeByte, text_byte());
      end
      push_beat(ModeByte, line_end());
    end else if (kind < 65) begin
      n = $urandom_range(1, 6);
      for (int unsigned i = 0; i < n; i++) push_beat(ModeByte, text_byte());
      push_beat(ModeByte, line_end());
    end else if (kind < 72) begin
      push_beat(ModeByte, line_end());
    end else if (kind < 80) begin
      push_beat(ModeByte, ChT);
      n = $urandom_range(29, 34);
      for (int unsigned i = 0; i < n; i++) push_beat(ModeByte, text_byte());
      push_beat(ModeByte, line_end());
    end else if (kind < 92) begin
      push_ticks($urandom_range(1, 8));
    end else begin
      push_beat(ModeByte, 8'($urandom_range(255)));
    end
  endtask

  // Sender: offers the next pending beat, holds it until accepted
  always @(posedge clk_i or negedge rst_ni) begin : drv
    logic     offer;
    in_beat_t nb;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
    end else begin
      offer = s_tvalid;
      if (s_tvalid && s_tready) begin
        take_beat(s_tuser, s_tdata);
        offer = 1'b0;
      end
      if (!offer && beat_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nb = beat_q.pop_front();
        s_tdata <= nb.ch;
        s_tuser <= nb.mode;
        offer = 1'b1;
      end
      s_tvalid <= offer;
    end
  end

  // Receiver: random stalls plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Reply checker
  always @(posedge clk_i) begin : mon
    reply_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (reply_q.size() == 0) begin
        report_mismatch($sformatf("unexpected reply byte %h last %b", m_tdata, m_tlast));
      end else begin
        want = reply_q.pop_front();
        if (m_tdata !== want.ch)
          report_mismatch($sformatf("reply byte %h, want %h", m_tdata, want.ch));
        if (m_tlast !== want.last)
          report_mismatch($sformatf("tlast %b on byte %h, want %b", m_tlast, m_tdata, want.last));
      end
    end
  end

  // Watchdog: too long without any beat on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("serial_time_set_clock_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned idle_tab[4];
    int unsigned stall_tab[4];
    idle_tab  = '{0, 64, 0, 22};
    stall_tab = '{0, 0, 64, 22};
    err_cnt   = 0;
    fed_cnt   = 0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_arm  = 1'b0;
    quiet_cycles = 0;
    clear_line();
    clk_set = 1'b0;
    clk_sod = '0;
    clk_ms  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty line, unset clock, negative and zero values,
    // set at end of day, NUL stop, non-T line, signed set, tick
    push_beat(ModeByte, ChLf);
    push_text("T0");
    push_beat(ModeByte, ChLf);
    push_text("T-9");
    push_beat(ModeByte, ChCr);
    push_beat(ModeTick, 8'hFF);
    push_text("T86399");
    push_beat(ModeByte, ChCr);
    push_beat(ModeByte, ChT);
    push_beat(ModeByte, 8'h00);
    push_text("5");
    push_beat(ModeByte, ChLf);
    push_beat(ModeByte, 8'hFF);
    push_beat(ModeByte, ChLf);
    push_text("T+60");
    push_beat(ModeByte, ChLf);

    for (int p = 0; p < 4; p++) begin
      @(negedge clk_i);
      idle_pct  = idle_tab[p];
      stall_pct = stall_tab[p];
      if (p == 2) hold_arm = 1'b1;
      fed_cnt = 0;
      while (fed_cnt < PhaseBeats) add_sequence();
      while (beat_q.size() != 0 || s_tvalid) @(negedge clk_i);
    end

    while (reply_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("serial_time_set_clock_top test passed");
    end else begin
      $display("serial_time_set_clock_top test failed");
    end
    $finish;
  end

endmodule
